// File: hdl/sitda_pkg.sv
// ----------------------------------------------------------------------------
// sitda_pkg: shared types, constants and the BCD add-3 helper for the signed integer to decimal
// ASCII converter.
// ----------------------------------------------------------------------------
package sitda_pkg;

   localparam int DEF_VALUE_WIDTH = 32;
   localparam int CHAR_W          = 6;
   localparam int DIGIT_W         = 4;

   localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;
   localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;
   localparam logic [CHAR_W-1:0] CH_NINE  = 6'd57;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SKIP,
      ST_SIGN,
      ST_EMIT
   } state_type;

   // shift-add-3 correction applied to one BCD digit before it is doubled
   function automatic logic [DIGIT_W-1:0] bcd_adjust(input logic [DIGIT_W-1:0] d);
      logic [DIGIT_W-1:0] r;
      if (d >= 4'd5) begin
         r = d + 4'd3;
      end else begin
         r = d;
      end
      return r;
   endfunction

endpackage

// File: hdl/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: signed integer to decimal ASCII text
//
// Takes one two's complement integer on the req_ channel and returns its
// decimal text on the rsp_ channel, one character per item, most significant
// first. Negative values lead with '-'; zero gives a single '0'; leading zeros
// are dropped; rsp_last marks the final character. The most negative value
// is converted by its true magnitude.
//
// Steps (VALUE_WIDTH = W, NDIG = W*3/10+1 BCD digits, 10 at W = 32):
//   - accept cycle: magnitude formed (one W-bit negate) and registered
//   - double dabble over all W magnitude bits: one magnitude bit shifts into the BCD
//     register per cycle, each digit corrected by add-3 in parallel
//   - finding the first nonzero digit, one digit per cycle
//   - the characters ('-' then digits), each taken while rsp_ready is high
//   One item is in flight at a time: req_ready is high only when the block
//   is idle.
// Stall: a character holds on rsp_ with rsp_valid high until rsp_ready;
//   conversion state is frozen meanwhile.
// Reset: synchronous, active high; returns to idle and drops any item.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii #(
   parameter int VALUE_WIDTH = sitda_pkg::DEF_VALUE_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [VALUE_WIDTH-1:0]       req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [sitda_pkg::CHAR_W-1:0] rsp_ascii_char,
   output logic                         rsp_last
);
   import sitda_pkg::*;

   // digits needed for 2**(W-1), with margin
   localparam int NDIG  = (VALUE_WIDTH * 3) / 10 + 1;
   localparam int BCD_W = NDIG * DIGIT_W;
   localparam int CW    = $clog2(VALUE_WIDTH + 1);
   localparam int DCW   = $clog2(NDIG + 1);

   state_type              state_ff, state_in;
   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic [BCD_W-1:0]       bcd_ff, bcd_in;
   logic [CW-1:0]          bit_cnt_ff, bit_cnt_in;
   logic [DCW-1:0]         dig_cnt_ff, dig_cnt_in;
   logic                   neg_ff, neg_in;

   logic [BCD_W-1:0]       bcd_adj;
   logic [DIGIT_W-1:0]     top_digit;
   logic                   req_take;
   logic                   rsp_take;

   assign top_digit = bcd_ff[BCD_W-1 -: DIGIT_W];
   assign req_take  = req_valid && req_ready;
   assign rsp_take  = rsp_valid && rsp_ready;

   // add-3 on every digit, all independent
   always_comb begin
      for (int i = 0; i < NDIG; i++) begin
         bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_adjust(bcd_ff[i*DIGIT_W +: DIGIT_W]);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            if (bit_cnt_ff == CW'(1)) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (top_digit != '0 || dig_cnt_ff == DCW'(1)) begin
               state_in = neg_ff ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (rsp_ready) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_ready && dig_cnt_ff == DCW'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready      = 1'b0;
      rsp_valid      = 1'b0;
      rsp_ascii_char = CH_ZERO + CHAR_W'(top_digit);
      rsp_last       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_SIGN: begin
            rsp_valid      = 1'b1;
            rsp_ascii_char = CH_MINUS;
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            rsp_last  = (dig_cnt_ff == DCW'(1));
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // datapath
   always_comb begin
      mag_in     = mag_ff;
      bcd_in     = bcd_ff;
      bit_cnt_in = bit_cnt_ff;
      dig_cnt_in = dig_cnt_ff;
      neg_in     = neg_ff;
      if (req_take) begin
         neg_in     = req_value[VALUE_WIDTH-1];
         mag_in     = req_value[VALUE_WIDTH-1] ? (~req_value + 1'b1) : req_value;
         bcd_in     = '0;
         bit_cnt_in = CW'(VALUE_WIDTH);
         dig_cnt_in = DCW'(NDIG);
      end else if (state_ff == ST_CONV) begin
         bcd_in     = {bcd_adj[BCD_W-2:0], mag_ff[VALUE_WIDTH-1]};
         mag_in     = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
         bit_cnt_in = bit_cnt_ff - CW'(1);
      end else if ((state_ff == ST_SKIP && top_digit == '0 && dig_cnt_ff != DCW'(1))
                   || (state_ff == ST_EMIT && rsp_take)) begin
         bcd_in     = {bcd_ff[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
         dig_cnt_in = dig_cnt_ff - DCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff     <= mag_in;
      bcd_ff     <= bcd_in;
      bit_cnt_ff <= bit_cnt_in;
      dig_cnt_ff <= dig_cnt_in;
      neg_ff     <= neg_in;
   end

endmodule

// File: hdl/sitda_checker.sv
// ----------------------------------------------------------------------------
// sitda_checker: port-level checks for the decimal ASCII converter
// Watches the top level's channels; bound to every instance below.
// ----------------------------------------------------------------------------
module sitda_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [sitda_pkg::CHAR_W-1:0] rsp_ascii_char,
   input logic                         rsp_last
);
   import sitda_pkg::*;

   logic req_take;

   assign req_take = req_valid && req_ready;

   // stalled character holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ascii_char) && $stable(rsp_last))
      else $error("rsp item changed while stalled");

   // only minus or digit codes
   a_rsp_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_ascii_char == CH_MINUS)
                    || (rsp_ascii_char >= CH_ZERO && rsp_ascii_char <= CH_NINE))
      else $error("rsp character out of range");

   // sign is never the final character
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ascii_char == CH_MINUS |-> !rsp_last)
      else $error("minus sign flagged as last");

   // one item at a time: no input taken while text is out
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req_take |-> !rsp_valid)
      else $error("item accepted while characters pending");

   // after an accept the block is busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req_ready)
      else $error("ready right after accept");

endmodule

bind signed_int_to_decimal_ascii sitda_checker u_sitda_checker (.*);

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for signed_int_to_decimal_ascii
//
// Sends signed 32-bit values on the req_ channel and checks the decimal text
// on the rsp_ channel. Each character is checked against a text predictor
// kept inside this bench. Stimulus has three parts: directed values (zero,
// extremes, decade boundaries), random values with the sender and receiver
// idling at changing rates, and a long output stall that fills the block.
// ----------------------------------------------------------------------------
module tb;
   import sitda_pkg::*;

   localparam int VW          = DEF_VALUE_WIDTH;
   localparam int MAX_DIGITS  = 10;
   localparam int DRAIN_WAIT  = 80;       // more than one full conversion
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 500;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
   } text_char_type;

   logic          clock     = 1'b0;
   logic          reset     = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   logic [VW-1:0] req_value = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic [CHAR_W-1:0] rsp_ascii_char;
   logic          rsp_last;

   // pending decimal text, oldest character at the front
   text_char_type pending_text[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int error_count   = 0;
   int cycle_count   = 0;
   int values_sent   = 0;
   int negatives_sent = 0;
   int chars_checked = 0;

   // long stall request: the test bumps hold_seq, the receiver counts it out
   int hold_len  = 0;
   int hold_seq  = 0;
   int hold_seen = 0;
   int hold_left = 0;

   signed_int_to_decimal_ascii #(.VALUE_WIDTH(VW)) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_last       (rsp_last)
   );

   always #4 clock = ~clock;

   // Work out the decimal text of one value and queue it.
   // Magnitude is taken as unsigned so the most negative value gives 2^31.
   function automatic void predict_text(input logic [VW-1:0] v);
      logic          neg;
      logic [VW-1:0] mag;
      logic [3:0]    digits[MAX_DIGITS];
      int            nd;
      text_char_type c;
      neg = v[VW-1];
      mag = neg ? (~v + 1'b1) : v;
      nd  = 0;
      if (mag == '0) begin
         c.ch   = CH_ZERO;
         c.last = 1'b1;
         pending_text.push_back(c);
         return;
      end
      while (mag != '0) begin
         digits[nd] = 4'(mag % 10);
         mag        = mag / 10;
         nd++;
      end
      if (neg) begin
         c.ch   = CH_MINUS;
         c.last = 1'b0;
         pending_text.push_back(c);
      end
      // most significant digit first
      for (int i = nd - 1; i >= 0; i--) begin
         c.ch   = CH_ZERO + CHAR_W'(digits[i]);
         c.last = (i == 0);
         pending_text.push_back(c);
      end
   endfunction

   // Input monitor and output checker share one edge-sampled process, so an
   // item is always predicted before any of its characters can be seen.
   always @(posedge clock) begin
      text_char_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_text(req_value);
            values_sent++;
            if (req_value[VW-1]) negatives_sent++;
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_text.size() == 0) begin
               $display("%0t: unexpected item, expected none, actual char %0d last %0b",
                        $time, rsp_ascii_char, rsp_last);
               error_count++;
            end else begin
               want = pending_text.pop_front();
               chars_checked++;
               if (rsp_ascii_char !== want.ch) begin
                  $display("%0t: rsp_ascii_char mismatch, expected %0d actual %0d",
                           $time, want.ch, rsp_ascii_char);
                  error_count++;
               end
               if (rsp_last !== want.last) begin
                  $display("%0t: rsp_last mismatch, expected %0b actual %0b",
                           $time, want.last, rsp_last);
                  error_count++;
               end
            end
         end
      end
   end

   // Receiver: random backoff, or a counted long hold when one is requested.
   always @(posedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen = hold_seq;
         hold_left = hold_len;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d characters outstanding",
                  $time, cycle_count, pending_text.size());
         $display("signed_int_to_decimal_ascii verification failed");
         $finish;
      end
   end

   // Offer one item; returns in the time step right after it is accepted,
   // with req_valid still high.
   task automatic send_value(input logic [VW-1:0] v);
      bit idled;
      idled = 1'b0;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         if (!idled) req_valid <= 1'b0;
         idled = 1'b1;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid, wait for all text to come back, then let the block settle.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_text.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // Random value with a spread of digit counts: full range, limited bit
   // widths, decade boundaries and small magnitudes; half of them negated.
   function automatic logic [VW-1:0] random_value();
      logic [VW-1:0] v;
      int            nbits;
      longint        p;
      case ($urandom_range(0, 3))
         0: v = $urandom;
         1: begin
            nbits = $urandom_range(1, VW);
            v     = $urandom;
            if (nbits < VW) v = v & ((VW'(1) << nbits) - 1'b1);
         end
         2: begin
            p = 1;
            repeat ($urandom_range(1, 9)) p = p * 10;
            v = VW'(p) + VW'($urandom_range(0, 2)) - 1'b1;
         end
         default: v = VW'($urandom_range(0, 20));
      endcase
      if ($urandom_range(0, 1)) v = ~v + 1'b1;
      return v;
   endfunction

   // Zero, both extremes, sign edges and decade boundaries, no idling.
   task automatic test_directed_values();
      logic [VW-1:0] vals[$];
      send_idle_pct = 0;
      recv_idle_pct = 0;
      vals = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99,
               32'd100, -32'sd9, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
               32'd999_999_999, 32'd1_000_000_000, -32'sd999_999_999,
               -32'sd1_000_000_000, 32'h5555_5555, 32'hAAAA_AAAA, 32'd12345,
               -32'sd120, 32'd7};
      foreach (vals[i]) send_value(vals[i]);
      wait_drained();
   endtask

   // Random values under one pair of idling rates.
   task automatic test_random_idle_mix(input int count, input int s_pct,
                                       input int r_pct);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      repeat (count) send_value(random_value());
      wait_drained();
   endtask

   // Receiver stalls for a long stretch while the sender keeps offering;
   // the first value parks on rsp_ and the next ones back up at req_.
   task automatic test_long_output_stall();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_len = HOLD_CYCLES;
      hold_seq = hold_seq + 1;
      send_value(32'h8000_0000);
      repeat (5) send_value(random_value());
      wait_drained();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_values();
      test_random_idle_mix(120, 33, 51);
      test_random_idle_mix(120, 51, 33);
      test_long_output_stall();
      test_random_idle_mix(120, 0, 0);

      $display("Converted %0d values (%0d negative) into %0d checked characters,",
               values_sent, negatives_sent, chars_checked);
      $display("under mixed idling on both sides and one long output stall.");
      if (error_count == 0) begin
         $display("signed_int_to_decimal_ascii verification clean");
      end else begin
         $display("signed_int_to_decimal_ascii verification failed");
      end
      $finish;
   end

endmodule
